// ----- hw/rtl/rgbwfe_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbwfe_pkg
// Shared types and constants of the rgbw event fade engine: payload words,
// controller states, command and status groups between control and datapath.
// ----------------------------------------------------------------------------
package rgbwfe_pkg;

   // sizes
   localparam int NUM_LEVELS  = 5;
   localparam int NUM_IDS     = 6;
   localparam int BASE_W      = 56;
   localparam int LEVEL_W     = 8;
   localparam int MS_W        = 18;
   localparam int NUMER_W     = LEVEL_W + MS_W;
   localparam int CH_W        = 3;
   localparam int BIT_W       = 3;
   localparam int CSR_IDX_W   = 3;

   localparam int DEF_TICKS_PER_SECOND = 1000;

   // channel codes, in register order
   localparam logic [CH_W-1:0] CH_RED        = 3'd0;
   localparam logic [CH_W-1:0] CH_GREEN      = 3'd1;
   localparam logic [CH_W-1:0] CH_BLUE       = 3'd2;
   localparam logic [CH_W-1:0] CH_WHITE      = 3'd3;
   localparam logic [CH_W-1:0] CH_BRIGHTNESS = 3'd4;
   localparam logic [CH_W-1:0] CH_DURATION   = 3'd5;

   localparam logic [CH_W-1:0]    CH_LAST      = CH_BRIGHTNESS;
   localparam logic [BIT_W-1:0]   BIT_TOP      = 3'd7;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 8'hFF;

   // action codes
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_EVENT = 1'b1;

   typedef struct packed {
      logic        action;
      logic [63:0] ev_code;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] white;
      logic [LEVEL_W-1:0] brightness;
      logic               fade_active;
      logic               levels_changed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             latch_req;
      logic             exec;
      logic             mul;
      logic             div_step;
      logic [BIT_W-1:0] div_bit;
      logic             write_lvl;
      logic [CH_W-1:0]  ch;
      logic             load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_event;
      logic fading;
   } ctrl_sts_type;

endpackage

// ----- hw/rtl/rgbwfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// rgbwfe_ctrl
// Sequencer of the fade engine: handshakes, channel walk and division steps.
// ----------------------------------------------------------------------------
module rgbwfe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rgbwfe_pkg::ctrl_sts_type sts,
   output rgbwfe_pkg::ctrl_cmd_type cmd
);

   rgbwfe_pkg::state_type state_ff, state_in;
   logic [rgbwfe_pkg::CH_W-1:0]  ch_ff, ch_in;
   logic [rgbwfe_pkg::BIT_W-1:0] bit_ff, bit_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rgbwfe_pkg::ST_IDLE;
         ch_ff        <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.ch       = ch_ff;
      cmd.div_bit  = bit_ff;
      case (state_ff)
         rgbwfe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = rgbwfe_pkg::ST_EXEC;
            end
         end
         rgbwfe_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            ch_in    = '0;
            if (!sts.is_event && sts.fading) begin
               state_in = rgbwfe_pkg::ST_MUL;
            end else begin
               state_in = rgbwfe_pkg::ST_DONE;
            end
         end
         rgbwfe_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            bit_in   = rgbwfe_pkg::BIT_TOP;
            state_in = rgbwfe_pkg::ST_DIV;
         end
         rgbwfe_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            bit_in       = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = rgbwfe_pkg::ST_WRITE;
            end
         end
         rgbwfe_pkg::ST_WRITE: begin
            cmd.write_lvl = 1'b1;
            ch_in         = ch_ff + 1'b1;
            if (ch_ff == rgbwfe_pkg::CH_LAST) begin
               state_in = rgbwfe_pkg::ST_DONE;
            end else begin
               state_in = rgbwfe_pkg::ST_MUL;
            end
         end
         rgbwfe_pkg::ST_DONE: begin
            // wait for a free output slot
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rgbwfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rgbwfe_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/rgbwfe_datapath.sv -----
// ----------------------------------------------------------------------------
// rgbwfe_datapath
// Id match, level stores, fade timer and shared multiply / restoring divider.
// ----------------------------------------------------------------------------
module rgbwfe_datapath #(
   parameter int unsigned TICKS_PER_SECOND = rgbwfe_pkg::DEF_TICKS_PER_SECOND
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rgbwfe_pkg::req_type                 req_data,
   input  logic                                csr_we,
   input  logic [rgbwfe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rgbwfe_pkg::BASE_W-1:0]       csr_wdata,
   input  rgbwfe_pkg::ctrl_cmd_type            cmd,
   output rgbwfe_pkg::ctrl_sts_type            sts,
   output rgbwfe_pkg::rsp_type                 rsp_data
);

   localparam int LW = rgbwfe_pkg::LEVEL_W;
   localparam int MW = rgbwfe_pkg::MS_W;
   localparam int NW = rgbwfe_pkg::NUMER_W;
   localparam int NL = rgbwfe_pkg::NUM_LEVELS;
   localparam int NI = rgbwfe_pkg::NUM_IDS;

   logic [rgbwfe_pkg::BASE_W-1:0] base_ff [NI];
   rgbwfe_pkg::req_type           in_ff;
   logic [LW-1:0] pend_ff  [NL];
   logic [LW-1:0] start_ff [NL];
   logic [LW-1:0] tgt_ff   [NL];
   logic [LW-1:0] cur_ff   [NL];
   logic [MW-1:0] elapsed_ff;
   logic [MW-1:0] duration_ff;
   logic          fading_ff;
   logic          changed_ff;
   logic [NW-1:0] rem_ff, rem_in;
   logic [LW-1:0] quot_ff, quot_in;
   rgbwfe_pkg::rsp_type rsp_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NI; i++) begin
            base_ff[i] <= '0;
         end
      end else if (csr_we && (int'(csr_index) < NI)) begin
         base_ff[csr_index] <= csr_wdata;
      end
   end

   // input word capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         in_ff <= req_data;
      end
   end

   // id match, lowest index wins
   logic [rgbwfe_pkg::BASE_W-1:0] ev_base;
   logic [LW-1:0]                 ev_value;
   logic                          hit;
   logic [rgbwfe_pkg::CH_W-1:0]   hit_ch;
   always_comb begin
      ev_base  = in_ff.ev_code[63:8];
      ev_value = in_ff.ev_code[7:0];
      hit      = 1'b0;
      hit_ch   = '0;
      for (int i = NI - 1; i >= 0; i--) begin
         if (base_ff[i] == ev_base) begin
            hit    = 1'b1;
            hit_ch = rgbwfe_pkg::CH_W'(i);
         end
      end
   end

   // fade duration in ticks
   logic [MW-1:0] dur_new;
   assign dur_new = MW'(MW'(ev_value) * MW'(TICKS_PER_SECOND));

   // per channel operands
   logic [LW-1:0] s_lv, t_lv, c_lv, diff, nv;
   logic          up, fade_end;
   logic [NW-1:0] numer, d_sh;
   always_comb begin
      s_lv     = start_ff[cmd.ch];
      t_lv     = tgt_ff[cmd.ch];
      c_lv     = cur_ff[cmd.ch];
      up       = (t_lv >= s_lv);
      diff     = up ? (t_lv - s_lv) : (s_lv - t_lv);
      numer    = NW'(diff) * NW'(elapsed_ff);
      if (!up) begin
         // round the step up when fading down, so the level rounds down
         numer = numer + NW'(duration_ff) - NW'(1);
      end
      fade_end = (elapsed_ff >= duration_ff);
      if (fade_end) begin
         nv = t_lv;
      end else if (up) begin
         nv = s_lv + quot_ff;
      end else begin
         nv = s_lv - quot_ff;
      end
      d_sh = NW'(duration_ff) << cmd.div_bit;
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (cmd.mul) begin
         rem_in  = numer;
         quot_in = '0;
      end else if (cmd.div_step && (rem_ff >= d_sh)) begin
         rem_in               = rem_ff - d_sh;
         quot_in[cmd.div_bit] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   // level stores and fade timer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            pend_ff[i]  <= (i == NL - 1) ? rgbwfe_pkg::LEVEL_FULL : '0;
            start_ff[i] <= (i == NL - 1) ? rgbwfe_pkg::LEVEL_FULL : '0;
            tgt_ff[i]   <= (i == NL - 1) ? rgbwfe_pkg::LEVEL_FULL : '0;
            cur_ff[i]   <= (i == NL - 1) ? rgbwfe_pkg::LEVEL_FULL : '0;
         end
         elapsed_ff  <= '0;
         duration_ff <= '0;
         fading_ff   <= 1'b0;
         changed_ff  <= 1'b0;
      end else begin
         if (cmd.latch_req) begin
            changed_ff <= 1'b0;
         end
         if (cmd.exec) begin
            if (in_ff.action == rgbwfe_pkg::ACT_EVENT) begin
               if (hit && (hit_ch != rgbwfe_pkg::CH_DURATION)) begin
                  pend_ff[hit_ch] <= ev_value;
               end else if (hit) begin
                  for (int i = 0; i < NL; i++) begin
                     start_ff[i] <= cur_ff[i];
                     tgt_ff[i]   <= pend_ff[i];
                  end
                  duration_ff <= dur_new;
                  elapsed_ff  <= '0;
                  if (dur_new == '0) begin
                     for (int i = 0; i < NL; i++) begin
                        cur_ff[i] <= pend_ff[i];
                     end
                     fading_ff  <= 1'b0;
                     changed_ff <= 1'b1;
                  end else begin
                     fading_ff <= 1'b1;
                  end
               end
            end else if (fading_ff && (elapsed_ff < duration_ff)) begin
               elapsed_ff <= elapsed_ff + 1'b1;
            end
         end
         if (cmd.write_lvl) begin
            cur_ff[cmd.ch] <= nv;
            if (nv != c_lv) begin
               changed_ff <= 1'b1;
            end
            if ((cmd.ch == rgbwfe_pkg::CH_LAST) && fade_end) begin
               fading_ff <= 1'b0;
            end
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.red            <= cur_ff[rgbwfe_pkg::CH_RED];
         rsp_ff.green          <= cur_ff[rgbwfe_pkg::CH_GREEN];
         rsp_ff.blue           <= cur_ff[rgbwfe_pkg::CH_BLUE];
         rsp_ff.white          <= cur_ff[rgbwfe_pkg::CH_WHITE];
         rsp_ff.brightness     <= cur_ff[rgbwfe_pkg::CH_BRIGHTNESS];
         rsp_ff.fade_active    <= fading_ff;
         rsp_ff.levels_changed <= changed_ff;
      end
   end

   assign rsp_data     = rsp_ff;
   assign sts.is_event = (in_ff.action == rgbwfe_pkg::ACT_EVENT);
   assign sts.fading   = fading_ff;

endmodule

// ----- hw/rtl/rgbw_event_fade_engine.sv -----
// ----------------------------------------------------------------------------
// rgbw_event_fade_engine
// Event driven rgbw level store with timed linear fades.
// ----------------------------------------------------------------------------
// Each accepted word gives one result word with the five current levels, the
// fade flag and a changed flag. An event report or a tick with no fade runs
// through exec to done. A tick during a fade walks the five channels, which
// share one multiplier and a restoring divider that yields one quotient bit
// a cycle: a multiply step, the divide steps and a level write per channel. A
// new word is taken once the sequencer is back in idle, even while the
// previous result waits on the output register. Id base registers are written
// through csr_we / csr_index / csr_wdata; indexes past the last are ignored.
// ----------------------------------------------------------------------------
module rgbw_event_fade_engine #(
   parameter int unsigned TICKS_PER_SECOND = rgbwfe_pkg::DEF_TICKS_PER_SECOND
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rgbwfe_pkg::req_type              req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rgbwfe_pkg::rsp_type              rsp_data,
   input  logic                             csr_we,
   input  logic [rgbwfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rgbwfe_pkg::BASE_W-1:0]    csr_wdata
);

   rgbwfe_pkg::ctrl_cmd_type cmd;
   rgbwfe_pkg::ctrl_sts_type sts;

   // sequencer
   rgbwfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   rgbwfe_datapath #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/rgbw_fade_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbw_fade_checker
// Watches the request, result and register ports of the fade engine. Each
// request word accepted runs through a local model of the levels, pending
// values and fade timer. The result word is queued and then compared field
// by field with the result word accepted in its turn.
// ----------------------------------------------------------------------------
module rgbw_fade_checker
   import rgbwfe_pkg::*;
#(
   parameter int unsigned TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BASE_W-1:0]    csr_wdata,
   output int                   mismatches,
   output int                   outstanding
);

   // local copy of the id bases and the level state
   logic [BASE_W-1:0]  id_base    [NUM_IDS];
   logic [LEVEL_W-1:0] pending_lv [NUM_LEVELS];
   logic [LEVEL_W-1:0] start_lv   [NUM_LEVELS];
   logic [LEVEL_W-1:0] target_lv  [NUM_LEVELS];
   logic [LEVEL_W-1:0] current_lv [NUM_LEVELS];
   logic [MS_W-1:0]    elapsed_ms;
   logic [MS_W-1:0]    duration_ms;
   logic               fading;

   rsp_type expected_levels_q [$];
   rsp_type want;
   int      fail_tally = 0;
   int      waiting    = 0;

   assign mismatches  = fail_tally;
   assign outstanding = waiting;

   // one line per mismatch, printing stops after 40
   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] wanted);
      fail_tally++;
      if (fail_tally <= 40)
         $display("mismatch %s: got %0h, want %0h at %0t", what, got, wanted, $time);
   endtask

   // level on the fade line, rounded down to a whole level
   function automatic logic [LEVEL_W-1:0] fade_point(input logic [LEVEL_W-1:0] from_lv,
                                                     input logic [LEVEL_W-1:0] to_lv,
                                                     input logic [MS_W-1:0] e,
                                                     input logic [MS_W-1:0] d);
      logic [63:0] span;
      logic [63:0] q;
      if (to_lv >= from_lv) begin
         span = {56'd0, to_lv - from_lv};
         q = (span * {46'd0, e}) / {46'd0, d};
         return from_lv + q[LEVEL_W-1:0];
      end
      span = {56'd0, from_lv - to_lv};
      q = (span * {46'd0, e} + {46'd0, d} - 64'd1) / {46'd0, d};
      return from_lv - q[LEVEL_W-1:0];
   endfunction

   // applies one request word to the local state, returns the result word
   function automatic rsp_type advance_levels(input req_type w);
      rsp_type            r;
      logic               changed;
      logic               hit;
      logic [CH_W-1:0]    ch;
      logic [LEVEL_W-1:0] value;
      logic [LEVEL_W-1:0] nv;
      logic [31:0]        span;
      int                 i;
      changed = 1'b0;
      hit     = 1'b0;
      ch      = CH_RED;
      value   = w.ev_code[LEVEL_W-1:0];
      if (w.action == ACT_EVENT) begin
         // scan downward so the lowest matching register wins
         for (i = NUM_IDS - 1; i >= 0; i--) begin
            if (id_base[i] == w.ev_code[63:8]) begin
               hit = 1'b1;
               ch  = CH_W'(i);
            end
         end
         if (hit && ch != CH_DURATION) begin
            pending_lv[ch] = value;
         end else if (hit) begin
            for (i = 0; i < NUM_LEVELS; i++) begin
               start_lv[i]  = current_lv[i];
               target_lv[i] = pending_lv[i];
            end
            span        = value * TICKS_PER_SECOND;
            duration_ms = span[MS_W-1:0];
            elapsed_ms  = '0;
            if (value == 0 || duration_ms == 0) begin
               for (i = 0; i < NUM_LEVELS; i++)
                  current_lv[i] = target_lv[i];
               fading  = 1'b0;
               changed = 1'b1;
            end else begin
               fading = 1'b1;
            end
         end
      end else if (fading) begin
         // tick: advance the timer, saturating at the fade length
         if (elapsed_ms < duration_ms)
            elapsed_ms = elapsed_ms + 1'b1;
         for (i = 0; i < NUM_LEVELS; i++) begin
            if (elapsed_ms >= duration_ms)
               nv = target_lv[i];
            else
               nv = fade_point(start_lv[i], target_lv[i], elapsed_ms, duration_ms);
            if (nv != current_lv[i])
               changed = 1'b1;
            current_lv[i] = nv;
         end
         if (elapsed_ms >= duration_ms)
            fading = 1'b0;
      end
      r.red            = current_lv[CH_RED];
      r.green          = current_lv[CH_GREEN];
      r.blue           = current_lv[CH_BLUE];
      r.white          = current_lv[CH_WHITE];
      r.brightness     = current_lv[CH_BRIGHTNESS];
      r.fade_active    = fading;
      r.levels_changed = changed;
      return r;
   endfunction

   // result words are checked before the request word of the same edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_IDS; i++)
            id_base[i] = '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            pending_lv[i] = '0;
            start_lv[i]   = '0;
            target_lv[i]  = '0;
            current_lv[i] = '0;
         end
         pending_lv[CH_BRIGHTNESS] = LEVEL_FULL;
         start_lv[CH_BRIGHTNESS]   = LEVEL_FULL;
         target_lv[CH_BRIGHTNESS]  = LEVEL_FULL;
         current_lv[CH_BRIGHTNESS] = LEVEL_FULL;
         elapsed_ms  = '0;
         duration_ms = '0;
         fading      = 1'b0;
         expected_levels_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels_q.size() == 0) begin
               note_mismatch("unexpected result word", 64'(rsp_data), 64'd0);
            end else begin
               want = expected_levels_q.pop_front();
               if (rsp_data.red !== want.red)
                  note_mismatch("red", 64'(rsp_data.red), 64'(want.red));
               if (rsp_data.green !== want.green)
                  note_mismatch("green", 64'(rsp_data.green), 64'(want.green));
               if (rsp_data.blue !== want.blue)
                  note_mismatch("blue", 64'(rsp_data.blue), 64'(want.blue));
               if (rsp_data.white !== want.white)
                  note_mismatch("white", 64'(rsp_data.white), 64'(want.white));
               if (rsp_data.brightness !== want.brightness)
                  note_mismatch("brightness", 64'(rsp_data.brightness),
                                64'(want.brightness));
               if (rsp_data.fade_active !== want.fade_active)
                  note_mismatch("fade_active", 64'(rsp_data.fade_active),
                                64'(want.fade_active));
               if (rsp_data.levels_changed !== want.levels_changed)
                  note_mismatch("levels_changed", 64'(rsp_data.levels_changed),
                                64'(want.levels_changed));
            end
         end
         if (req_valid && req_ready)
            expected_levels_q.push_back(advance_levels(req_data));
         // indexes past the last register are dropped
         if (csr_we && csr_index < NUM_IDS)
            id_base[csr_index] = csr_wdata;
      end
      waiting <= expected_levels_q.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the rgbw event fade engine. Directed words hit the id and
// value extremes, immediate and timed fades, restarts and a fade followed
// over many ticks. Random bursts of pending, duration, tick and stray words
// follow under several id base settings, with random gaps on both channels.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
   import rgbwfe_pkg::*;

   localparam int unsigned FADE_TICKS = DEF_TICKS_PER_SECOND;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam int FADE_RUN_TICKS = 40;

   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
   localparam logic [BASE_W-1:0]    BASE_ONES    = '1;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BASE_W-1:0]    csr_wdata = '0;

   int   mismatches;
   int   outstanding;
   int   cycles  = 0;
   int   sent    = 0;
   bit   idle_on = 1'b1;
   logic [BASE_W-1:0] base_set [NUM_IDS];

   always #5 clock = ~clock;

   rgbw_event_fade_engine #(
      .TICKS_PER_SECOND (FADE_TICKS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rgbw_fade_checker #(
      .TICKS_PER_SECOND (FADE_TICKS)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // result side stalls in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [BASE_W-1:0] rand_base();
      logic [63:0] r;
      r = rand64();
      return r[BASE_W-1:0];
   endfunction

   // levels lean on the two ends of the range
   function automatic logic [LEVEL_W-1:0] rand_level();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return LEVEL_FULL;
         default: return LEVEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   // fade lengths in seconds, mostly short or immediate
   function automatic logic [LEVEL_W-1:0] rand_span();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick < 5) return 8'd1;
      if (pick < 7) return 8'd2;
      if (pick == 7) return LEVEL_FULL;
      return LEVEL_W'($urandom_range(1, 255));
   endfunction

   // one request word, with an optional gap ahead of it
   task automatic send_word(input logic act, input logic [63:0] id);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {act, id};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_event(input logic [CH_W-1:0] ch, input logic [LEVEL_W-1:0] value);
      send_word(ACT_EVENT, {base_set[ch], value});
   endtask

   // tick words carry random ids that the block must ignore
   task automatic send_ticks(input int n);
      repeat (n) send_word(ACT_TICK, rand64());
   endtask

   // hold off until every result word is back
   task automatic settle_engine();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // writes base_set, plus the two unused indexes
   task automatic load_bases();
      for (int i = 0; i < NUM_IDS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= base_set[i];
         @(posedge clock);
      end
      csr_index <= IDX_SPARE_LO;
      csr_wdata <= rand_base();
      @(posedge clock);
      csr_index <= IDX_SPARE_HI;
      csr_wdata <= '0;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int pick;
      int target;
      int chunk;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset bases are all zero: every register matches, red takes the word
      for (int i = 0; i < NUM_IDS; i++)
         base_set[i] = '0;
      send_word(ACT_TICK, '1);
      send_event(CH_DURATION, 8'hAB);
      send_word(ACT_EVENT, {56'h1, 8'h5A});
      settle_engine();

      // distinct bases, both ends of the id range in use
      for (int i = 0; i < NUM_IDS; i++)
         base_set[i] = rand_base();
      base_set[CH_RED]      = '0;
      base_set[CH_DURATION] = BASE_ONES;
      load_bases();

      send_event(CH_RED, LEVEL_FULL);
      send_event(CH_GREEN, 8'h00);
      send_event(CH_BLUE, 8'h5A);
      send_event(CH_WHITE, LEVEL_FULL);
      send_event(CH_BRIGHTNESS, 8'h00);
      send_word(ACT_EVENT, {BASE_ONES - 1'b1, 8'h33});
      // zero length applies the pending levels at once
      send_event(CH_DURATION, 8'h00);
      send_event(CH_RED, 8'h00);
      send_event(CH_GREEN, LEVEL_FULL);
      send_event(CH_BLUE, 8'hA5);
      send_event(CH_BRIGHTNESS, LEVEL_FULL);
      send_event(CH_DURATION, 8'd1);
      send_ticks(4);
      // restart while fading, then the longest fade
      send_event(CH_DURATION, 8'd2);
      send_ticks(3);
      send_event(CH_DURATION, LEVEL_FULL);
      send_ticks(2);
      send_event(CH_DURATION, 8'h00);
      send_ticks(1);
      settle_engine();

      // one fade followed over many ticks, levels moving both ways
      send_event(CH_RED, LEVEL_FULL);
      send_event(CH_GREEN, 8'h00);
      send_event(CH_BLUE, rand_level());
      send_event(CH_WHITE, 8'h80);
      send_event(CH_BRIGHTNESS, 8'h01);
      send_event(CH_DURATION, 8'd1);
      send_ticks(FADE_RUN_TICKS);
      settle_engine();

      // random bursts under several base settings, the last with no gaps
      for (int phase = 0; phase < 4; phase++) begin
         chunk = 160;
         for (int i = 0; i < NUM_IDS; i++)
            base_set[i] = rand_base();
         if (phase == 1) begin
            // overlapping bases, lower index takes the word
            base_set[CH_GREEN]      = base_set[CH_RED];
            base_set[CH_BRIGHTNESS] = base_set[CH_WHITE];
         end else if (phase == 2) begin
            // all ones everywhere: only red is reachable
            for (int i = 0; i < NUM_IDS; i++)
               base_set[i] = BASE_ONES;
            chunk = 60;
         end
         idle_on = (phase != 3);
         load_bases();
         target = sent + chunk;
         while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               // pending values, a duration word, then ticks
               repeat ($urandom_range(0, 5))
                  send_event(CH_W'($urandom_range(0, 4)), rand_level());
               send_event(CH_DURATION, rand_span());
               send_ticks($urandom_range(0, 40));
            end else if (pick < 68) begin
               send_event(CH_W'($urandom_range(0, 4)), rand_level());
            end else if (pick < 80) begin
               send_ticks($urandom_range(1, 12));
            end else if (pick < 90) begin
               send_word(ACT_EVENT, rand64());
            end else if (pick < 97) begin
               send_event(CH_DURATION, rand_span());
            end else begin
               settle_engine();
            end
         end
         settle_engine();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ----- rgbw_event_fade_engine.f -----
hw/rtl/rgbwfe_pkg.sv
hw/rtl/rgbwfe_ctrl.sv
hw/rtl/rgbwfe_datapath.sv
hw/rtl/rgbw_event_fade_engine.sv
tb/rgbw_fade_checker.sv
tb/tb_top.sv
